### design/ebet_pkg.sv
// Package for the encoder button event tracker.
// Holds the sample and result word types and the register reset value.
// No dependencies.
package ebet_pkg;

  localparam logic [15:0] LONG_PRESS_MS_RESET = 16'd1000;

  typedef struct packed {
    logic signed [31:0] encoder_position;
    logic               button_level;
    logic        [31:0] now_ms;
    logic               consume;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] delta;
    logic               short_press;
    logic               long_press;
    logic               held;
  } result_t;

  // Input register contents handed to the tracking core.
  typedef struct packed {
    logic    valid;
    sample_t data;
  } stage_t;

endpackage

### design/ebet_if.sv
// Valid/ready channel interfaces for sample words and result words.
// Depends on ebet_pkg for the payload types.
interface ebet_sample_if;
  import ebet_pkg::*;
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ebet_result_if;
  import ebet_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/ebet_in_stage.sv
// Input register for sample words.
// Depends on ebet_pkg and ebet_sample_if.
module ebet_in_stage (
  input  logic              clk,
  input  logic              rst,
  ebet_sample_if.sink       sample,
  input  logic              advance,
  output ebet_pkg::stage_t  stage
);
  import ebet_pkg::*;

  logic    valid;
  sample_t data;

  // Take a new word when empty or when the held one moves on.
  assign sample.ready = !valid || advance;
  assign stage.valid  = valid;
  assign stage.data   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sample.ready) begin
      valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      data <= sample.data;
    end
  end

endmodule

### design/ebet_core.sv
// Tracking state, delta accumulator, press detection and result register.
// Depends on ebet_pkg and ebet_result_if.
module ebet_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata,
  input  ebet_pkg::stage_t stage,
  output logic             advance,
  ebet_result_if.source    result
);
  import ebet_pkg::*;

  logic [15:0] long_press_ms;
  logic        primed;
  logic [31:0] last_position;
  logic        last_level;
  logic [31:0] press_start;
  logic        long_handled;
  logic [31:0] delta_sum;
  logic        short_flag;
  logic        long_flag;
  logic        out_valid;
  result_t     out_data;

  logic        primed_next;
  logic [31:0] last_position_next;
  logic        last_level_next;
  logic [31:0] press_start_next;
  logic        long_handled_next;
  logic [31:0] delta_sum_next;
  logic        short_flag_next;
  logic        long_flag_next;
  logic [31:0] diff;
  logic [31:0] sum;
  logic [31:0] sat_sum;
  logic [31:0] elapsed;
  logic        ovf;
  logic        level;
  result_t     res;

  assign advance      = stage.valid && (!out_valid || result.ready);
  assign result.valid = out_valid;
  assign result.data  = out_data;
  assign level        = stage.data.button_level;

  assign diff    = stage.data.encoder_position - last_position;
  assign sum     = delta_sum + diff;
  assign ovf     = (~(delta_sum[31] ^ diff[31])) & (delta_sum[31] ^ sum[31]);
  assign sat_sum = ovf ? (delta_sum[31] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum;
  assign elapsed = stage.data.now_ms - press_start;

  always_comb begin
    primed_next        = 1'b1;
    last_position_next = stage.data.encoder_position;
    last_level_next    = level;
    press_start_next   = press_start;
    long_handled_next  = long_handled;
    delta_sum_next     = delta_sum;
    short_flag_next    = short_flag;
    long_flag_next     = long_flag;
    if (primed) begin
      delta_sum_next = sat_sum;
      if (last_level && !level) begin
        press_start_next  = stage.data.now_ms;
        long_handled_next = 1'b0;
      end else if (!last_level && !level) begin
        if (!long_handled && (elapsed >= {16'd0, long_press_ms})) begin
          long_flag_next    = 1'b1;
          long_handled_next = 1'b1;
        end
      end else if (!last_level && level) begin
        if (!long_handled) begin
          short_flag_next = 1'b1;
        end
      end
    end
    res.delta       = delta_sum_next;
    res.short_press = short_flag_next;
    res.long_press  = long_flag_next;
    res.held        = !last_level_next;
    // Drop the accumulated delta and flags once reported.
    if (stage.data.consume) begin
      delta_sum_next  = 32'd0;
      short_flag_next = 1'b0;
      long_flag_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_MS_RESET;
    end else if (cfg_we) begin
      long_press_ms <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed        <= 1'b0;
      last_position <= 32'd0;
      last_level    <= 1'b1;
      press_start   <= 32'd0;
      long_handled  <= 1'b0;
      delta_sum     <= 32'd0;
      short_flag    <= 1'b0;
      long_flag     <= 1'b0;
    end else if (advance) begin
      primed        <= primed_next;
      last_position <= last_position_next;
      last_level    <= last_level_next;
      press_start   <= press_start_next;
      long_handled  <= long_handled_next;
      delta_sum     <= delta_sum_next;
      short_flag    <= short_flag_next;
      long_flag     <= long_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  a_primed_after_word: assert property (@(posedge clk) disable iff (rst)
    advance |=> primed)
    else $error("tracker not primed after first word");

  a_consume_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && stage.data.consume) |=> (delta_sum == 32'd0 && !short_flag && !long_flag))
    else $error("consume did not clear delta and flags");

  a_long_marks_handled: assert property (@(posedge clk) disable iff (rst)
    $rose(long_flag) |-> long_handled)
    else $error("long press flagged without marking the hold handled");

  a_held_tracks_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.held == !last_level))
    else $error("held output disagrees with tracked level");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced word produced no result");

endmodule

### design/encoder_button_event_tracker.sv
// Top level of the encoder button event tracker.
// Depends on ebet_pkg, ebet_if, ebet_in_stage and ebet_core.
//
// Usage:
//   sample : sink channel of poll words (encoder position, active-low button
//            level, millisecond time, consume bit). A word moves at a rising
//            edge with valid and ready both high.
//   result : source channel, exactly one result word per sample word, in
//            order: saturating delta, sticky short and long press flags and
//            the held level as they stand after the sample.
//   cfg_we / cfg_wdata : write of long_press_ms, taken at any edge with
//            cfg_we high; write it only while the block is idle.
// A sample word passes the input register, loaded at the accepting edge, and
// then the result register, loaded through the tracking logic once that
// register is free. Throughput is one word per cycle while the receiver
// takes results; the combinational state update in the core (position
// subtract, saturating add, hold-time compare) allows it.
// Reset (rst, synchronous, active high) empties both registers, restores
// long_press_ms to 1000 and returns the tracker to its unprimed state, so
// the next sample only records position and button level.
// When the receiver stalls, the result word holds; the input register still
// takes one more word, then sample.ready falls until the result moves.
module encoder_button_event_tracker (
  input  logic          clk,
  input  logic          rst,
  ebet_sample_if.sink   sample,
  ebet_result_if.source result,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);
  import ebet_pkg::*;

  stage_t stage;
  logic   advance;

  // Hold the incoming word until the core can take it.
  ebet_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .advance (advance),
    .stage   (stage)
  );

  // Advance the tracking state and load the result register.
  ebet_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .advance   (advance),
    .result    (result)
  );

endmodule

### bench/encoder_button_event_tracker_tb.sv
// Testbench for the encoder button event tracker: directed and random poll words
// checked against a built-in tracker model, with bursty input and a stalling receiver.
// Depends on ebet_pkg, ebet_if and the encoder_button_event_tracker RTL.
`timescale 1ns / 100ps

module encoder_button_event_tracker_tb;
  import ebet_pkg::*;

  localparam int unsigned QUIET_LIMIT    = 2000; // cycles with no word moving
  localparam int unsigned HOLDOFF_CYCLES = 300;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES   = 4;    // drain margin after the last report

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  ebet_sample_if sample_ch ();
  ebet_result_if result_ch ();

  encoder_button_event_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch.sink),
    .result    (result_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Tracker model state, mirrored from what the block should hold
  logic        trk_primed;
  logic [31:0] trk_last_pos;
  logic        trk_last_level;
  logic [31:0] trk_press_start;
  logic        trk_long_done;
  logic [31:0] trk_delta;
  logic        trk_short;
  logic        trk_long;
  logic [15:0] hold_ms;

  result_t     expected_reports[$];

  // Run bookkeeping
  int unsigned fail_count;
  int unsigned samples_sent;
  int unsigned reports_checked;
  int unsigned short_seen;
  int unsigned long_seen;
  int unsigned sat_seen;
  int unsigned hold_settings;
  int unsigned quiet_cycles;

  // Sender pacing and receiver hold-off request
  int unsigned burst_left;
  bit          sender_gaps_on;
  bit          holdoff_req;

  // Random user generator, kept across phases so presses may span them
  logic [31:0] user_pos;
  logic [31:0] user_now;
  logic        user_level;
  int unsigned user_run;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Add two words, clamping at the 32-bit signed limits
  function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    if ((a[31] == b[31]) && (s[31] != a[31]))
      return a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s;
  endfunction

  // Advance the tracker model by one poll word and return the report it yields
  function automatic result_t track_sample(input sample_t s);
    result_t     r;
    logic [31:0] elapsed;
    if (!trk_primed) begin
      // first word after reset: record position and level only
      trk_last_pos   = s.encoder_position;
      trk_last_level = s.button_level;
      trk_primed     = 1'b1;
    end else begin
      trk_delta    = clamp_add(trk_delta, s.encoder_position - trk_last_pos);
      trk_last_pos = s.encoder_position;
      elapsed      = s.now_ms - trk_press_start;
      if (trk_last_level && !s.button_level) begin
        trk_press_start = s.now_ms;
        trk_long_done   = 1'b0;
      end else if (!trk_last_level && !s.button_level) begin
        if (!trk_long_done && (elapsed >= {16'd0, hold_ms})) begin
          trk_long      = 1'b1;
          trk_long_done = 1'b1;
        end
      end else if (!trk_last_level && s.button_level) begin
        if (!trk_long_done)
          trk_short = 1'b1;
      end
      trk_last_level = s.button_level;
    end
    r.delta       = trk_delta;
    r.short_press = trk_short;
    r.long_press  = trk_long;
    r.held        = ~trk_last_level;
    if (s.consume) begin
      trk_delta = 32'd0;
      trk_short = 1'b0;
      trk_long  = 1'b0;
    end
    return r;
  endfunction

  function automatic sample_t make_sample(input logic [31:0] pos, input logic level,
                                          input logic [31:0] now, input logic consume);
    sample_t s;
    s.encoder_position = pos;
    s.button_level     = level;
    s.now_ms           = now;
    s.consume          = consume;
    return s;
  endfunction

  // Offer one word, hold it until taken, then record the expected report.
  // Call just after a rising edge. Between bursts, valid may drop for a random gap.
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    expected_reports.push_back(track_sample(s));
    samples_sent++;
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (sender_gaps_on && ($urandom_range(0, 2) != 0))
        gap = $urandom_range(1, 8);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and let every outstanding report come back
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write long_press_ms while the block is idle and mirror it in the model
  task automatic write_hold_time(input logic [15:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hold_ms   = value;
    hold_settings++;
  endtask

  // Unprimed start-up with the button already down: the first word only records,
  // then the hold is timed from a press start of zero; release after a long press
  // must not raise the short flag.
  task automatic test_startup_pressed();
    send_sample(make_sample(32'h7FFF_FFFF, 1'b0, 32'd5, 1'b0));
    send_sample(make_sample(32'h7FFF_FFFF, 1'b0, 32'd999, 1'b0));
    send_sample(make_sample(32'h7FFF_FFFE, 1'b0, 32'd1000, 1'b0));
    send_sample(make_sample(32'h7FFF_FFFE, 1'b1, 32'd2000, 1'b1));
  endtask

  // Position wrap and clamping at both signed limits
  task automatic test_delta_clamp();
    send_sample(make_sample(32'h0000_0000, 1'b1, 32'd2100, 1'b1));
    send_sample(make_sample(32'h7FFF_FFFF, 1'b1, 32'd2101, 1'b0));
    send_sample(make_sample(32'hFFFF_FFFE, 1'b1, 32'd2102, 1'b0));
    send_sample(make_sample(32'hFFFF_FFFF, 1'b1, 32'd2103, 1'b1));
    send_sample(make_sample(32'h7FFF_FFFF, 1'b1, 32'd2104, 1'b0));
    send_sample(make_sample(32'hFFFF_FFFF, 1'b1, 32'd2105, 1'b1));
    send_sample(make_sample(32'h8000_0000, 1'b1, 32'd2106, 1'b1));
  endtask

  // Long press timed across the millisecond wrap, then a short press
  task automatic test_press_kinds();
    send_sample(make_sample(32'h8000_0000, 1'b0, 32'hFFFF_FF00, 1'b0));
    send_sample(make_sample(32'h8000_0000, 1'b0, 32'h0000_02E7, 1'b0));
    send_sample(make_sample(32'h8000_0000, 1'b0, 32'h0000_02E8, 1'b0));
    send_sample(make_sample(32'h8000_0000, 1'b0, 32'h0000_5000, 1'b0));
    send_sample(make_sample(32'h8000_0000, 1'b1, 32'h0000_5001, 1'b1));
    send_sample(make_sample(32'h8000_0001, 1'b0, 32'h1234_5678, 1'b0));
    send_sample(make_sample(32'h8000_0001, 1'b1, 32'h1234_567B, 1'b1));
  endtask

  // Hold time of zero: the first held word after the press counts as long
  task automatic test_zero_hold();
    write_hold_time(16'd0);
    send_sample(make_sample(32'h0000_0010, 1'b0, 32'h0000_0055, 1'b0));
    send_sample(make_sample(32'h0000_0010, 1'b0, 32'h0000_0055, 1'b0));
    send_sample(make_sample(32'h0000_0010, 1'b1, 32'h0000_0056, 1'b1));
  endtask

  // Random user traffic: mostly plausible knob turns and press runs with
  // monotonic time, with some fully random noise words mixed in.
  task automatic run_user_traffic(input int unsigned n_items, input int unsigned consume_odds,
                                  input bit with_holdoff);
    sample_t     s;
    int unsigned i;
    for (i = 0; i < n_items; i++) begin
      if (with_holdoff && (i == 20))
        holdoff_req = 1'b1;
      if ($urandom_range(0, 99) < 12) begin
        s.encoder_position = $urandom;
        s.button_level     = $urandom_range(0, 1);
        s.now_ms           = $urandom;
        s.consume          = $urandom_range(0, 1);
      end else begin
        if (user_run == 0) begin
          user_level = ~user_level;
          user_run   = $urandom_range(1, 8);
        end
        user_run--;
        case ($urandom_range(0, 19))
          0:       user_pos = $urandom;
          1:       user_pos = user_pos + $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
          2:       user_pos = user_pos - $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
          default: user_pos = user_pos + $urandom_range(0, 8) - 4;
        endcase
        user_now = user_now + $urandom_range(0, (hold_ms / 3) + 1);
        s.encoder_position = user_pos;
        s.button_level     = user_level;
        s.now_ms           = user_now;
        s.consume          = ($urandom_range(1, consume_odds) == 1);
      end
      send_sample(s);
    end
  endtask

  // Receiver: ready follows a mode that changes every so often, and a
  // requested hold-off keeps it low for a long stretch.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    logic [3:0]  tick;
    result_ch.ready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 4'd0;
    forever begin
      @(posedge clk);
      tick = tick + 4'd1;
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left   = HOLDOFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 200);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= $urandom_range(0, 1);
          2:       result_ch.ready <= (tick[2:0] != 3'd5) && (tick != 4'd14);
          default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each report that moves with the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("report with no sample outstanding: delta %0d", result_ch.data.delta);
        fail_count++;
      end else begin
        exp_r = expected_reports.pop_front();
        reports_checked++;
        if (exp_r.short_press) short_seen++;
        if (exp_r.long_press) long_seen++;
        if ((exp_r.delta == 32'sh7FFF_FFFF) || (exp_r.delta == 32'sh8000_0000)) sat_seen++;
        if (result_ch.data.delta !== exp_r.delta) begin
          $error("delta: expected %0d, got %0d", exp_r.delta, result_ch.data.delta);
          fail_count++;
        end
        if (result_ch.data.short_press !== exp_r.short_press) begin
          $error("short_press: expected %0b, got %0b", exp_r.short_press,
                 result_ch.data.short_press);
          fail_count++;
        end
        if (result_ch.data.long_press !== exp_r.long_press) begin
          $error("long_press: expected %0b, got %0b", exp_r.long_press,
                 result_ch.data.long_press);
          fail_count++;
        end
        if (result_ch.data.held !== exp_r.held) begin
          $error("held: expected %0b, got %0b", exp_r.held, result_ch.data.held);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Hold every input at a known value from time zero
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 16'd0;
    sample_ch.valid  <= 1'b0;
    sample_ch.data   <= '0;
    trk_primed       = 1'b0;
    trk_last_pos     = 32'd0;
    trk_last_level   = 1'b1;
    trk_press_start  = 32'd0;
    trk_long_done    = 1'b0;
    trk_delta        = 32'd0;
    trk_short        = 1'b0;
    trk_long         = 1'b0;
    hold_ms          = LONG_PRESS_MS_RESET;
    fail_count       = 0;
    samples_sent     = 0;
    reports_checked  = 0;
    short_seen       = 0;
    long_seen        = 0;
    sat_seen         = 0;
    hold_settings    = 0;
    quiet_cycles     = 0;
    burst_left       = 1;
    sender_gaps_on   = 1'b1;
    holdoff_req      = 1'b0;
    user_pos         = $urandom;
    user_now         = $urandom;
    user_level       = 1'b1;
    user_run         = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset hold time, then a zero hold time
    test_startup_pressed();
    test_delta_clamp();
    test_press_kinds();
    test_zero_hold();

    // Random part across a spread of hold times, extremes included
    write_hold_time(16'd1);
    run_user_traffic(250, 4, 1'b0);
    write_hold_time(16'd65535);
    run_user_traffic(250, 4, 1'b1);
    write_hold_time(16'($urandom_range(2, 300)));
    run_user_traffic(250, 40, 1'b0);
    write_hold_time(16'd1000);
    sender_gaps_on = 1'b0;
    run_user_traffic(250, 6, 1'b0);
    sender_gaps_on = 1'b1;
    write_hold_time(16'($urandom_range(1, 65535)));
    run_user_traffic(250, 3, 1'b0);
    write_hold_time(16'($urandom_range(2, 40)));
    run_user_traffic(280, 8, 1'b1);

    wait_idle();
    repeat (10) @(posedge clk);

    $display("Sent %0d samples over %0d hold-time settings; checked %0d reports",
             samples_sent, hold_settings, reports_checked);
    $display("Reports with short press %0d, long press %0d, clamped delta %0d",
             short_seen, long_seen, sat_seen);
    if ((fail_count == 0) && (expected_reports.size() == 0)) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
